### sv/page_frame_allocator_mapper_assert.svh
// Assertion macros used by the port-level checker file of the frame allocator.
`ifndef PAGE_FRAME_ALLOCATOR_MAPPER_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_MAPPER_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define PFAM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfam same-cycle check failed");

// Next-cycle implication, sampled on the rising edge, off during reset.
`define PFAM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfam next-cycle check failed");

`endif

### sv/pfam_pkg.sv
// Package with the constants, codes and transaction types of the frame allocator.
package pfam_pkg;

    localparam int FRAMES          = 32;
    localparam int DIRS            = 4;
    localparam int FRAME_SIZE_LOG2 = 22;

    localparam int ENTRIES   = 1024;
    localparam int PAGE_W    = 10;
    localparam int FRAME_W   = $clog2(FRAMES);
    localparam int CNT_W     = $clog2(FRAMES + 1);
    localparam int DIR_W     = (DIRS > 1) ? $clog2(DIRS) : 1;
    localparam int ADDR_W    = DIR_W + PAGE_W;
    localparam int DIR_DEPTH = DIRS * ENTRIES;

    // Directory entry layout
    localparam int ENTRY_W     = 14;
    localparam int BIT_PS      = 10;
    localparam int BIT_USER    = 11;
    localparam int BIT_WRITE   = 12;
    localparam int BIT_PRESENT = 13;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_CHECK = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [1:0]  dir_index;
        logic [9:0]  virt_page;
        logic [31:0] amount;
    } pfam_req_t;

    typedef struct packed {
        logic        ok;
        logic [9:0]  frame_index;
        logic [10:0] frees_left;
    } pfam_rsp_t;

    // Commit to the frame pool
    typedef struct packed {
        logic               alloc;
        logic               free_en;
        logic [FRAME_W-1:0] frame;
    } pfam_pool_cmd_t;

    // Pool status; any_free and lowest are registered from the registered bitmap and lag count after a commit
    typedef struct packed {
        logic               any_free;
        logic [FRAME_W-1:0] lowest;
        logic [CNT_W-1:0]   count;
    } pfam_pool_stat_t;

endpackage

### sv/page_frame_allocator_mapper.sv
// Top level of the bitmap frame allocator with 4 MB page directory mapping.
//
//   channel | signals                     | payload
//   --------+-----------------------------+---------------------------------
//   req     | req_valid / req_ready       | opcode, dir_index, virt_page, amount
//   rsp     | rsp_valid / rsp_ready       | ok, frame_index, frees_left
//
// Every request is accepted with a directory read, then modified, written back and
// loaded into the response register. The registered read data of the directory memory sets this split.
// After reset the directory is cleared one entry a cycle, all 4096 entries, with req_ready low.
// req_ready is high whenever the block is idle, also while a response waits.
// A stalled response holds the block in its write-back cycle until rsp_ready.
module page_frame_allocator_mapper (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  pfam_pkg::pfam_req_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output pfam_pkg::pfam_rsp_t rsp
);
    import pfam_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    localparam int NEED_W = 32 - FRAME_SIZE_LOG2 + 1;
    localparam int CMP_W  = 33;

    logic [1:0]         state_reg, state_next;
    logic [ADDR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    pfam_req_t          req_reg;
    logic               rsp_valid_reg, rsp_valid_next;
    pfam_rsp_t          rsp_reg, rsp_next;

    logic               accept;
    logic               commit;
    logic               dir_ok;
    logic [ADDR_W-1:0]  req_addr;
    logic [ADDR_W-1:0]  cur_addr;
    logic [ENTRY_W-1:0] entry;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               alloc_do;
    logic               unmap_do;
    logic               release_do;
    logic               check_ok;
    logic [NEED_W-1:0]  need;
    logic [CNT_W-1:0]   count_after;
    logic               probe_used;
    pfam_pool_cmd_t     pool_cmd;
    pfam_pool_stat_t    pool_stat;

    assign accept   = req_valid && req_ready;
    assign req_addr = {DIR_W'(req.dir_index), req.virt_page};
    assign cur_addr = {DIR_W'(req_reg.dir_index), req_reg.virt_page};
    assign commit   = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp_ready);
    assign dir_ok   = 32'(req_reg.dir_index) < DIRS;

    pfam_dir_mem u_dir_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (req_addr),
        .rdata (entry)
    );

    pfam_frame_pool u_pool (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (pool_cmd),
        .probe_frame (entry[PAGE_W-1:0]),
        .probe_used  (probe_used),
        .stat        (pool_stat)
    );

    always_comb
    begin
        alloc_do   = (req_reg.opcode == OP_ALLOC) && dir_ok && pool_stat.any_free;
        unmap_do   = (req_reg.opcode == OP_FREE) && dir_ok
                     && entry[BIT_PRESENT] && entry[BIT_PS];
        release_do = unmap_do && probe_used;
        need       = NEED_W'(req_reg.amount >> FRAME_SIZE_LOG2)
                     + NEED_W'(|req_reg.amount[FRAME_SIZE_LOG2-1:0]);
        check_ok   = CMP_W'(pool_stat.count) >= CMP_W'(need);
    end

    always_comb
    begin
        pool_cmd.alloc   = commit && alloc_do;
        pool_cmd.free_en = commit && release_do;
        pool_cmd.frame   = alloc_do ? pool_stat.lowest : entry[FRAME_W-1:0];
    end

    // Memory write: clearing pass, or write back of the modified entry
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cur_addr;
        mem_wdata = '0;
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
        end
        else if (commit && alloc_do)
        begin
            mem_we                 = 1'b1;
            mem_wdata[BIT_PRESENT] = 1'b1;
            mem_wdata[BIT_WRITE]   = 1'b1;
            mem_wdata[BIT_USER]    = 1'b1;
            mem_wdata[BIT_PS]      = 1'b1;
            mem_wdata[PAGE_W-1:0]  = PAGE_W'(pool_stat.lowest);
        end
        else if (commit && unmap_do)
        begin
            mem_we                         = 1'b1;
            mem_wdata                      = entry;
            mem_wdata[BIT_PRESENT]         = 1'b0;
            mem_wdata[PAGE_W-1:0]          = '0;
        end
    end

    always_comb
    begin
        count_after = pool_stat.count;
        if (alloc_do)
        begin
            count_after = pool_stat.count - CNT_W'(1);
        end
        else if (release_do)
        begin
            count_after = pool_stat.count + CNT_W'(1);
        end

        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (commit)
        begin
            rsp_valid_next       = 1'b1;
            rsp_next.frees_left  = 11'(count_after);
            rsp_next.frame_index = '0;
            rsp_next.ok          = 1'b0;
            case (req_reg.opcode)
                OP_ALLOC:
                begin
                    rsp_next.ok = alloc_do;
                    if (alloc_do)
                    begin
                        rsp_next.frame_index = PAGE_W'(pool_stat.lowest);
                    end
                end
                OP_FREE:
                begin
                    rsp_next.ok = unmap_do;
                    if (release_do)
                    begin
                        rsp_next.frame_index = entry[PAGE_W-1:0];
                    end
                end
                OP_CHECK:
                begin
                    rsp_next.ok = check_ok;
                end
                default:
                begin
                    rsp_next.ok = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(DIR_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold the request and response payloads
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### sv/pfam_dir_mem.sv
// Page directory memory: one write port, one read port with registered data.
module pfam_dir_mem (
    input  logic                              clk,
    input  logic                              we,
    input  logic [pfam_pkg::ADDR_W-1:0]       waddr,
    input  logic [pfam_pkg::ENTRY_W-1:0]      wdata,
    input  logic                              re,
    input  logic [pfam_pkg::ADDR_W-1:0]       raddr,
    output logic [pfam_pkg::ENTRY_W-1:0]      rdata
);
    import pfam_pkg::*;

    logic [ENTRY_W-1:0] mem [DIR_DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/pfam_frame_pool.sv
// Frame-in-use bitmap, free counter and registered lowest-free-frame search.
module pfam_frame_pool (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pfam_pkg::pfam_pool_cmd_t          cmd,
    input  logic [9:0]                        probe_frame,
    output logic                              probe_used,
    output pfam_pkg::pfam_pool_stat_t         stat
);
    import pfam_pkg::*;

    logic [FRAMES-1:0]  used_reg, used_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [FRAME_W-1:0] lowest_reg, lowest_next;
    logic               found_reg, found_next;

    always_comb
    begin
        used_next  = used_reg;
        count_next = count_reg;
        if (cmd.alloc)
        begin
            used_next[cmd.frame] = 1'b1;
            count_next           = count_reg - CNT_W'(1);
        end
        else if (cmd.free_en)
        begin
            used_next[cmd.frame] = 1'b0;
            count_next           = count_reg + CNT_W'(1);
        end
    end

    // Priority encoder from frame 1 upward; frame 0 stays reserved
    always_comb
    begin
        lowest_next = '0;
        found_next  = 1'b0;
        for (int f = FRAMES - 1; f >= 1; f--)
        begin
            if (!used_reg[f])
            begin
                lowest_next = FRAME_W'(f);
                found_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg   <= FRAMES'(1);
            count_reg  <= CNT_W'(FRAMES - 1);
            lowest_reg <= '0;
            found_reg  <= 1'b0;
        end
        else
        begin
            used_reg   <= used_next;
            count_reg  <= count_next;
            lowest_reg <= lowest_next;
            found_reg  <= found_next;
        end
    end

    assign probe_used = (32'(probe_frame) < FRAMES) && used_reg[probe_frame[FRAME_W-1:0]];

    assign stat.any_free = found_reg;
    assign stat.lowest   = lowest_reg;
    assign stat.count    = count_reg;

endmodule

### sv/pfam_checker.sv
// Port-level checker for the frame allocator, bound to the top level.
`include "page_frame_allocator_mapper_assert.svh"

module pfam_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input pfam_pkg::pfam_req_t req,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input pfam_pkg::pfam_rsp_t rsp
);
    import pfam_pkg::*;

    // A stalled response transaction holds its payload
    `PFAM_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

    // One request in flight: no accept right after an accept
    `PFAM_ASSERT_NEXT(a_one_in_flight, clk, rst_n, req_valid && req_ready, !req_ready)

    // Frame 0 is reserved, so the free count never reaches FRAMES
    `PFAM_ASSERT_IMPL(a_count_bound, clk, rst_n, rsp_valid, 32'(rsp.frees_left) < FRAMES)

    // A reported frame means success and lies within the pool
    `PFAM_ASSERT_IMPL(a_frame_ok, clk, rst_n, rsp_valid && (rsp.frame_index != '0),
        rsp.ok && (32'(rsp.frame_index) < FRAMES))

endmodule

bind page_frame_allocator_mapper pfam_checker u_pfam_checker (.*);

### tb/page_frame_allocator_mapper_checker.sv
// Checker that predicts and compares the responses of the frame allocator.
module page_frame_allocator_mapper_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_ready,
    input  pfam_pkg::pfam_req_t req,
    input  logic                rsp_valid,
    input  logic                rsp_ready,
    input  pfam_pkg::pfam_rsp_t rsp,
    output int                  failures,
    output int                  outstanding
);
    import pfam_pkg::*;

    logic               frame_busy [FRAMES];
    int                 spare_frames;
    logic [ENTRY_W-1:0] pde [DIRS][ENTRIES];
    pfam_rsp_t          expected_rsp [$];
    int                 err_cnt;

    initial
    begin
        for (int f = 0; f < FRAMES; f++)
            frame_busy[f] = (f == 0);
        for (int d = 0; d < DIRS; d++)
            for (int p = 0; p < ENTRIES; p++)
                pde[d][p] = '0;
        spare_frames = FRAMES - 1;
        err_cnt      = 0;
    end

    // Apply one request to the shadow pool and directories, return its response.
    function automatic pfam_rsp_t allocator_step(pfam_req_t r);
        pfam_rsp_t          p;
        logic [ENTRY_W-1:0] e;
        int                 f;
        int                 pick;
        longint             need;
        p    = '0;
        pick = 0;
        case (r.opcode)
            OP_ALLOC:
            begin
                if (int'(r.dir_index) < DIRS)
                begin
                    for (f = FRAMES - 1; f >= 1; f--)
                        if (!frame_busy[f])
                            pick = f;
                    if (pick != 0)
                    begin
                        frame_busy[pick] = 1'b1;
                        spare_frames--;
                        e                = '0;
                        e[BIT_PRESENT]   = 1'b1;
                        e[BIT_WRITE]     = 1'b1;
                        e[BIT_USER]      = 1'b1;
                        e[BIT_PS]        = 1'b1;
                        e[PAGE_W-1:0]    = pick[PAGE_W-1:0];
                        pde[r.dir_index][r.virt_page] = e;
                        p.ok          = 1'b1;
                        p.frame_index = pick[9:0];
                    end
                end
            end
            OP_FREE:
            begin
                if (int'(r.dir_index) < DIRS)
                begin
                    e = pde[r.dir_index][r.virt_page];
                    if (e[BIT_PRESENT] && e[BIT_PS])
                    begin
                        f              = int'(e[PAGE_W-1:0]);
                        e[BIT_PRESENT] = 1'b0;
                        e[PAGE_W-1:0]  = '0;
                        pde[r.dir_index][r.virt_page] = e;
                        p.ok = 1'b1;
                        // clear the entry even when the frame is not released
                        if (f < FRAMES && frame_busy[f])
                        begin
                            frame_busy[f] = 1'b0;
                            spare_frames++;
                            p.frame_index = f[9:0];
                        end
                    end
                end
            end
            OP_CHECK:
            begin
                need = longint'(r.amount >> FRAME_SIZE_LOG2) +
                       (((r.amount & ((32'd1 << FRAME_SIZE_LOG2) - 32'd1)) != 32'd0) ? 1 : 0);
                p.ok = (longint'(spare_frames) >= need);
            end
            default:
            begin
            end
        endcase
        p.frees_left = spare_frames[10:0];
        return p;
    endfunction

    always @(posedge clk)
    begin
        pfam_rsp_t want;
        if (rst_n)
        begin
            if (req_valid && req_ready)
                expected_rsp.push_back(allocator_step(req));
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: unexpected response ok=%0b frame_index=%0d frees_left=%0d",
                             $time, rsp.ok, rsp.frame_index, rsp.frees_left);
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.ok !== want.ok)
                    begin
                        err_cnt++;
                        $display("%0t: ok mismatch, expected %0b, actual %0b",
                                 $time, want.ok, rsp.ok);
                    end
                    if (rsp.frame_index !== want.frame_index)
                    begin
                        err_cnt++;
                        $display("%0t: frame_index mismatch, expected %0d, actual %0d",
                                 $time, want.frame_index, rsp.frame_index);
                    end
                    if (rsp.frees_left !== want.frees_left)
                    begin
                        err_cnt++;
                        $display("%0t: frees_left mismatch, expected %0d, actual %0d",
                                 $time, want.frees_left, rsp.frees_left);
                    end
                end
            end
        end
        failures    <= err_cnt;
        outstanding <= expected_rsp.size();
    end

endmodule

### tb/tb_page_frame_allocator_mapper.sv
// Testbench top: stimulus, handshake idling, watchdog and verdict for the frame allocator.
module tb_page_frame_allocator_mapper;
    import pfam_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         STALL_LIMIT = 12000;
    localparam int         PHASE_ITEMS = 410;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    pfam_req_t req       = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    pfam_rsp_t rsp;
    int        failures;
    int        outstanding;

    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        quiet_cycles   = 0;
    int        op_count [4];

    // Coarse view of the pool used only to steer the stimulus.
    bit          mapped_at [DIR_DEPTH];
    logic [11:0] mapped_list [$];
    int          held     = 0;
    int          pool_cap = FRAMES - 1;

    page_frame_allocator_mapper u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    page_frame_allocator_mapper_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [11:0] fresh_addr();
        logic [11:0] a;
        do
            a = 12'($urandom_range(0, DIR_DEPTH - 1));
        while (mapped_at[a]);
        return a;
    endfunction

    task automatic issue(input logic [1:0] op, input logic [1:0] dir,
                         input logic [9:0] page, input logic [31:0] amount);
        pfam_req_t   r;
        logic [11:0] a;
        int          idx;
        r.opcode    = op;
        r.dir_index = dir;
        r.virt_page = page;
        r.amount    = amount;
        a           = {dir, page};
        idx         = 0;
        if (op == OP_ALLOC && held < pool_cap)
        begin
            // overwrite of a live entry leaks its old frame
            if (mapped_at[a])
                pool_cap--;
            else
            begin
                mapped_at[a] = 1'b1;
                mapped_list.push_back(a);
                held++;
            end
        end
        else if (op == OP_FREE && mapped_at[a])
        begin
            mapped_at[a] = 1'b0;
            held--;
            foreach (mapped_list[i])
                if (mapped_list[i] == a)
                    idx = i;
            mapped_list.delete(idx);
        end
        op_count[op]++;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    initial
    begin
        logic [11:0] a;
        logic [31:0] amount;
        int          sel;
        int          full_tries;
        bit          filling;
        bit          want_alloc;
        full_tries = 0;
        filling    = 1'b1;
        foreach (op_count[i])
            op_count[i] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed corners: capacity edges, directory edges, bad unmaps, overwrite
        issue(OP_CHECK, 2'd0, 10'd0, 32'd0);
        issue(OP_CHECK, 2'd3, 10'h3FF, 32'hFFFF_FFFF);
        issue(OP_CHECK, 2'd1, 10'd5, 32'd31 << FRAME_SIZE_LOG2);
        issue(OP_CHECK, 2'd2, 10'd6, (32'd31 << FRAME_SIZE_LOG2) + 32'd1);
        issue(OP_CHECK, 2'd0, 10'd7, (32'd31 << FRAME_SIZE_LOG2) - 32'd1);
        issue(OP_ALLOC, 2'd0, 10'd0, 32'hFFFF_FFFF);
        issue(OP_ALLOC, 2'd3, 10'h3FF, 32'd0);
        issue(OP_ALLOC, 2'd1, 10'h2AA, 32'hAAAA_AAAA);
        issue(OP_ALLOC, 2'd2, 10'h155, 32'h5555_5555);
        issue(OP_FREE, 2'd0, 10'd1, 32'd0);
        issue(OP_FREE, 2'd3, 10'h3FF, 32'd0);
        issue(OP_FREE, 2'd3, 10'h3FF, 32'd0);
        issue(OP_ALLOC, 2'd3, 10'h3FF, 32'd0);
        issue(OP_ALLOC, 2'd0, 10'd0, 32'd0);
        issue(OP_FREE, 2'd0, 10'd0, 32'd0);
        issue(OP_UNUSED, 2'd3, 10'h3FF, 32'hFFFF_FFFF);
        issue(OP_UNUSED, 2'd0, 10'd0, 32'd0);
        issue(OP_CHECK, 2'd0, 10'd0, 32'd1);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // swing the pool between full and empty
                if (filling && held >= pool_cap && full_tries >= 3)
                begin
                    filling    = 1'b0;
                    full_tries = 0;
                end
                if (!filling && held == 0)
                    filling = 1'b1;
                sel = $urandom_range(0, 99);
                if (sel < 3)
                    issue(OP_UNUSED, 2'($urandom()), 10'($urandom()), $urandom());
                else if (sel < 18)
                begin
                    case ($urandom_range(0, 3))
                        0: amount = $urandom();
                        1: amount = 32'($urandom_range(0, 40)) << FRAME_SIZE_LOG2;
                        2: amount = (32'($urandom_range(0, 40)) << FRAME_SIZE_LOG2) +
                                    32'($urandom_range(1, 3));
                        default: amount = (32'($urandom_range(1, 40)) << FRAME_SIZE_LOG2) -
                                          32'd1;
                    endcase
                    issue(OP_CHECK, 2'($urandom()), 10'($urandom()), amount);
                end
                else if (sel < 22)
                    issue(OP_FREE, 2'($urandom()), 10'($urandom()), $urandom());
                else
                begin
                    want_alloc = filling ? ($urandom_range(0, 3) != 0)
                                         : ($urandom_range(0, 3) == 0);
                    if (want_alloc || mapped_list.size() == 0)
                    begin
                        if (mapped_list.size() != 0 && $urandom_range(0, 399) == 0)
                            a = mapped_list[$urandom_range(0, mapped_list.size() - 1)];
                        else
                            a = fresh_addr();
                        if (held >= pool_cap)
                            full_tries++;
                        issue(OP_ALLOC, a[11:10], a[9:0], $urandom());
                    end
                    else
                    begin
                        a = mapped_list[$urandom_range(0, mapped_list.size() - 1)];
                        issue(OP_FREE, a[11:10], a[9:0], $urandom());
                    end
                end
            end
        end
        req_valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("ran %0d alloc, %0d unmap, %0d check and %0d unused-opcode requests",
                 op_count[OP_ALLOC], op_count[OP_FREE], op_count[OP_CHECK],
                 op_count[OP_UNUSED]);
        $display("directed corners, then pool fill/drain swings under four idle/stall mixes");
        if (failures == 0 && outstanding == 0)
            $display("TB_OK");
        else
        begin
            $display("%0d mismatches, %0d responses never arrived", failures, outstanding);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
